// File: rtl/pump_schedule_uv_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Pump schedule / UV controller assertion macros
// Clocked assertion helpers for the controller top level, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef PUMP_SCHEDULE_UV_CONTROLLER_TOP_MACROS_SVH
`define PUMP_SCHEDULE_UV_CONTROLLER_TOP_MACROS_SVH

// implication checked at every edge outside reset
`define PSUV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// invariant that holds on every edge, reset included
`define PSUV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/psuv_pkg.sv
// ----------------------------------------------------------------------------
// Pump schedule / UV controller package
// Word types, mode and flow phase codes, register map and time constants.
// ----------------------------------------------------------------------------
`default_nettype none
package psuv_pkg;

  localparam int MIN_RUN_SECONDS_DEF = 300;

  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_SCHED  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_FLOW = 2'd1;
  localparam logic [1:0] PHASE_DRY  = 2'd2;

  localparam logic [2:0] REG_LATE_LIMIT  = 3'd0;
  localparam logic [2:0] REG_MAX_RUN     = 3'd1;
  localparam logic [2:0] REG_FLOW_GRACE  = 3'd2;
  localparam logic [2:0] REG_FLOW_STOP   = 3'd3;
  localparam logic [2:0] REG_UV_DELAY    = 3'd4;
  localparam logic [2:0] REG_RUN_MINUTES = 3'd5;
  localparam logic [2:0] REG_PERIOD_DAYS = 3'd6;
  localparam logic [2:0] REG_FIRST_START = 3'd7;

  localparam logic [31:0] LATE_LIMIT_RST = 32'd3600;
  localparam logic [31:0] MAX_RUN_RST    = 32'd43200;
  localparam logic [31:0] FLOW_GRACE_RST = 32'd30;
  localparam logic [31:0] FLOW_STOP_RST  = 32'd5;
  localparam logic [31:0] UV_DELAY_RST   = 32'd5;
  localparam logic [7:0]  PERIOD_RST     = 8'd255;
  localparam logic [31:0] START_RST      = 32'hFFFF_FFFF;

  // period in seconds fits 25 bits (255 days)
  localparam int PER_W = 25;
  localparam logic [PER_W-1:0] PERIOD_SEC_RST = 25'(255 * 86400);

  typedef struct packed {
    logic [31:0] now_time;
    logic        flow_detected;
    logic        manual_request;
    logic        auto_mode;
    logic        schedule_enable;
    logic        uv_enable;
    logic        stop_job;
  } in_t;

  typedef struct packed {
    logic        pump_on;
    logic        uv_on;
    logic [1:0]  mode;
    logic        override_locked;
    logic [31:0] next_start_time;
    logic [31:0] last_change_time;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/pump_schedule_uv_controller_top.sv
// ----------------------------------------------------------------------------
// Pump schedule / UV controller top level
// Three-mode pump controller with flow tracking, UV delay and a bit-serial
// remainder unit that advances the next scheduled start by whole periods.
// ----------------------------------------------------------------------------
// Each word passes through accept, evaluate and output register load; a tick
//   that hits the schedule also runs the bit-serial remainder unit in between.
// One word is handled at a time: the input is stalled from accept until the
//   result is loaded into the output register, which out_stall can hold off.
// Reset (rst, synchronous, active high): idle mode, override locked, pump and
//   UV off, times cleared, next start all ones, registers to their defaults.
`default_nettype none
`include "pump_schedule_uv_controller_top_macros.svh"
module pump_schedule_uv_controller_top
  import psuv_pkg::*;
#(
  parameter int MIN_RUN_SECONDS = MIN_RUN_SECONDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire in_t         in_word,
  input  wire logic        in_valid,
  output logic             in_stall,
  // result words
  output out_t             out_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // ---------------- configuration registers ----------------
  logic [31:0]      late_limit, max_run, flow_grace, flow_stop_delay, uv_delay;
  logic [15:0]      run_minutes;
  logic [21:0]      run_sec;      // run_minutes * 60, kept alongside
  logic [7:0]       period_days;
  logic [PER_W-1:0] period_sec;   // period_days * 86400, kept alongside
  logic [31:0]      first_start_time;

  // ---------------- controller state ----------------
  logic [1:0]  state;
  logic [1:0]  mode_reg;
  logic        lock_flag, pump_reg, uv_reg, uv_enable_prev;
  logic [31:0] pump_start_time, pump_stop_time;
  logic [31:0] flow_start_time, flow_stop_time;
  logic [31:0] next_start, last_change;
  logic [1:0]  flow_phase;
  in_t         in_q;

  // remainder unit: dividend shifts out MSB first, one bit per cycle
  logic [31:0]      div_shift;
  logic [PER_W-1:0] rem;
  logic [4:0]       div_cnt;
  logic [PER_W:0]   rem_trial;

  logic cfg_wr;
  logic [2:0] cfg_idx;
  logic out_load;   // result register takes the evaluated word this edge

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    unique case (cfg_idx)
      REG_LATE_LIMIT:  prdata = late_limit;
      REG_MAX_RUN:     prdata = max_run;
      REG_FLOW_GRACE:  prdata = flow_grace;
      REG_FLOW_STOP:   prdata = flow_stop_delay;
      REG_UV_DELAY:    prdata = uv_delay;
      REG_RUN_MINUTES: prdata = {16'd0, run_minutes};
      REG_PERIOD_DAYS: prdata = {24'd0, period_days};
      REG_FIRST_START: prdata = first_start_time;
      default:         prdata = '0;
    endcase
  end

  // ---------------- tick evaluation ----------------
  logic [31:0] t;
  logic [31:0] pst;
  logic [31:0] fst_next, fsp_next;
  logic [1:0]  phase_next;
  logic [1:0]  mode_next;
  logic        lock_next, pump_next, uv_next, uvp_next;
  logic [31:0] pstart_next, pstop_next, lc_next;
  logic        hit;
  logic        stopped;
  logic [31:0] late;

  always_comb begin
    t           = in_q.now_time;
    // stop pulse clears the end time before anything else
    pst         = in_q.stop_job ? 32'd0 : pump_stop_time;
    fst_next    = flow_start_time;
    fsp_next    = flow_stop_time;
    phase_next  = flow_phase;
    mode_next   = mode_reg;
    lock_next   = lock_flag;
    pump_next   = pump_reg;
    uv_next     = uv_reg;
    uvp_next    = uv_enable_prev;
    pstart_next = pump_start_time;
    pstop_next  = pst;
    lc_next     = last_change;
    hit         = 1'b0;
    stopped     = 1'b0;
    late        = t - next_start;

    // flow edge recording; phase acts as the valid mark
    if (in_q.flow_detected) begin
      if (flow_phase != PHASE_FLOW) begin
        fst_next   = t;
        fsp_next   = '0;
        phase_next = PHASE_FLOW;
      end
    end else if (flow_phase != PHASE_DRY) begin
      fst_next   = '0;
      fsp_next   = t;
      phase_next = PHASE_DRY;
    end

    unique case (mode_reg)
      MODE_MANUAL: begin
        stopped = !in_q.manual_request;
      end
      MODE_SCHED: begin
        if (in_q.manual_request) begin
          if (!lock_flag) begin
            lock_next = 1'b1;
            lc_next   = t;
          end
        end else if (lock_flag) begin
          lock_next = 1'b0;
          lc_next   = t;
        end
        if (!in_q.auto_mode || !in_q.schedule_enable || t >= pst) begin
          stopped = 1'b1;
        end else if ((pst - t) >= max_run) begin
          stopped = 1'b1;
        end else if (!in_q.flow_detected && (t - pump_start_time) >= flow_grace &&
                     (t - fsp_next) >= flow_stop_delay) begin
          stopped = 1'b1;
        end
      end
      default: begin
        if (in_q.manual_request && !lock_flag) begin
          pump_next   = 1'b1;
          pstart_next = t;
          mode_next   = MODE_MANUAL;
          lc_next     = t;
        end else begin
          if (!in_q.manual_request && lock_flag) begin
            lock_next = 1'b0;
            lc_next   = t;
          end
          if (in_q.auto_mode && in_q.schedule_enable && t >= next_start) begin
            hit = 1'b1;
            if (late <= late_limit && {10'd0, run_sec} >= 32'(MIN_RUN_SECONDS)) begin
              pump_next   = 1'b1;
              pstart_next = t;
              pstop_next  = t + {10'd0, run_sec};
              mode_next   = MODE_SCHED;
            end
            lc_next = t;
          end
        end
      end
    endcase

    if (stopped) begin
      pump_next   = 1'b0;
      pstart_next = '0;
      mode_next   = MODE_IDLE;
      lc_next     = t;
    end

    if (in_q.uv_enable != uv_enable_prev) begin
      uvp_next = in_q.uv_enable;
      lc_next  = t;
    end

    // UV follows pump and flow with a delay on both flow edges; UV disable or pump off drops it at once
    if (!uv_reg && in_q.uv_enable && pump_next && in_q.flow_detected &&
        (t - fst_next) >= uv_delay) begin
      uv_next = 1'b1;
      lc_next = t;
    end else if (uv_reg && (!in_q.uv_enable || !pump_next ||
                 (!in_q.flow_detected && (t - fsp_next) >= uv_delay))) begin
      uv_next = 1'b0;
      lc_next = t;
    end
  end

  assign rem_trial = {rem, div_shift[31]};

  // ---------------- sequencer and state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      late_limit       <= LATE_LIMIT_RST;
      max_run          <= MAX_RUN_RST;
      flow_grace       <= FLOW_GRACE_RST;
      flow_stop_delay  <= FLOW_STOP_RST;
      uv_delay         <= UV_DELAY_RST;
      run_minutes      <= '0;
      run_sec          <= '0;
      period_days      <= PERIOD_RST;
      period_sec       <= PERIOD_SEC_RST;
      first_start_time <= START_RST;
      mode_reg         <= MODE_IDLE;
      lock_flag        <= 1'b1;
      pump_reg         <= 1'b0;
      uv_reg           <= 1'b0;
      uv_enable_prev   <= 1'b0;
      pump_start_time  <= '0;
      pump_stop_time   <= '0;
      flow_start_time  <= '0;
      flow_stop_time   <= '0;
      next_start       <= START_RST;
      last_change      <= '0;
      flow_phase       <= PHASE_NONE;
      div_cnt          <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_LATE_LIMIT:  late_limit      <= pwdata;
          REG_MAX_RUN:     max_run         <= pwdata;
          REG_FLOW_GRACE:  flow_grace      <= pwdata;
          REG_FLOW_STOP:   flow_stop_delay <= pwdata;
          REG_UV_DELAY:    uv_delay        <= pwdata;
          REG_RUN_MINUTES: begin
            run_minutes <= pwdata[15:0];
            run_sec     <= pwdata[15:0] * SEC_PER_MIN;
          end
          REG_PERIOD_DAYS: begin
            // zero period is ignored
            if (pwdata[7:0] != 8'd0) begin
              period_days <= pwdata[7:0];
              period_sec  <= pwdata[7:0] * SEC_PER_DAY;
            end
          end
          REG_FIRST_START: begin
            first_start_time <= pwdata;
            next_start       <= pwdata;
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_q  <= in_word;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          mode_reg        <= mode_next;
          lock_flag       <= lock_next;
          pump_reg        <= pump_next;
          uv_reg          <= uv_next;
          uv_enable_prev  <= uvp_next;
          pump_start_time <= pstart_next;
          pump_stop_time  <= pstop_next;
          flow_start_time <= fst_next;
          flow_stop_time  <= fsp_next;
          flow_phase      <= phase_next;
          last_change     <= lc_next;
          if (hit) begin
            div_shift <= late;
            rem       <= '0;
            div_cnt   <= '0;
            state     <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          // restoring remainder step, one dividend bit per cycle
          if (rem_trial >= {1'b0, period_sec}) begin
            rem <= PER_W'(rem_trial - {1'b0, period_sec});
          end else begin
            rem <= rem_trial[PER_W-1:0];
          end
          div_shift <= {div_shift[30:0], 1'b0};
          div_cnt   <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= S_OUT;
          end
          if (state == S_DIV && div_cnt == 5'd31) begin
            // next start = now - late % period + period
            next_start <= in_q.now_time
                          - {7'd0, (rem_trial >= {1'b0, period_sec})
                                   ? PER_W'(rem_trial - {1'b0, period_sec})
                                   : rem_trial[PER_W-1:0]}
                          + {7'd0, period_sec};
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_word.pump_on          <= pump_reg;
            out_word.uv_on            <= uv_reg;
            out_word.mode             <= mode_reg;
            out_word.override_locked  <= lock_flag;
            out_word.next_start_time  <= next_start;
            out_word.last_change_time <= last_change;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `PSUV_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  `PSUV_ASSERT(a_mode_legal, mode_reg != MODE_UNUSED, "mode register holds unused code")
  `PSUV_ASSERT(a_uv_needs_pump, uv_reg |-> pump_reg, "UV on while pump off")
  `PSUV_ASSERT(a_rem_bound, (state == S_DIV) |-> (rem < period_sec), "remainder out of range")
  `PSUV_ASSERT(a_out_done, (state == S_OUT && !(out_valid && out_stall)) |=> (state == S_IDLE && out_valid), "result not loaded")

endmodule
`default_nettype wire
